// ===== rtl/core/ppt_pkg.sv =====
// ---------------------------------------------------------------------------
// ppt_pkg
// Shared types and constants for the pulse-period tachometer.
// ---------------------------------------------------------------------------
package ppt_pkg;

	localparam int CFG_W      = 32;
	localparam int RPM_W      = 24;
	localparam int RPM_BASE_W = 26;
	localparam int REG_IDX_W  = 1;

	localparam logic [RPM_BASE_W-1:0] RPM_BASE        = 26'd60000000;
	localparam logic [CFG_W-1:0]      LOCKOUT_RST     = 32'd3000;
	localparam logic [CFG_W-1:0]      TIMEOUT_RST     = 32'd1000000;
	localparam logic [RPM_W-1:0]      RPM_MAX         = 24'hFFFFFF;

	localparam logic [REG_IDX_W-1:0]  REG_LOCKOUT     = 1'b0;
	localparam logic [REG_IDX_W-1:0]  REG_TIMEOUT     = 1'b1;

	localparam logic                  CMD_EDGE        = 1'b0;
	localparam logic                  CMD_QUERY       = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic edge_upd;
		logic div_start;
		logic div_step;
		logic load_stop;
		logic load_div;
	} ppt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic stop_now;
	} ppt_sts_t;

endpackage

// ===== rtl/core/ppt_ctrl.sv =====
// ---------------------------------------------------------------------------
// ppt_ctrl
// Sequencer: accepts events, runs the divider, owns the result valid flag.
// ---------------------------------------------------------------------------
module ppt_ctrl #(
	parameter int FRACTION_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              command,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output ppt_pkg::ppt_cmd_t cmd,
	input  ppt_pkg::ppt_sts_t sts
);

	localparam int NUM_W = ppt_pkg::RPM_BASE_W + FRACTION_BITS;
	localparam int CNT_W = $clog2(NUM_W);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_FIN  = 3'b100
	} ppt_state_t;

	ppt_state_t       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             in_accept;
	logic             out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || (command == ppt_pkg::CMD_QUERY && !out_free);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					if (command == ppt_pkg::CMD_EDGE) begin
						cmd.edge_upd = 1'b1;
					end else if (sts.stop_now) begin
						cmd.load_stop = 1'b1;
					end else begin
						cmd.div_start = 1'b1;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_FIN: begin
				cmd.load_div = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once it is taken, reload below
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load_stop || cmd.load_div) begin
				out_valid_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.div_start) begin
						state_q <= S_DIV;
						cnt_q   <= CNT_W'(NUM_W - 1);
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN || cmd.load_stop))
		else $error("result valid rose without a load");

	a_cnt_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q != '0) |=> (state_q == S_DIV && cnt_q == $past(cnt_q) - 1'b1))
		else $error("divider step count did not advance");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && out_stall) |=> state_q == S_FIN)
		else $error("quotient left before output slot freed");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !(cmd.edge_upd || cmd.load_stop || cmd.div_start))
		else $error("event taken while divider busy");

endmodule

// ===== rtl/core/ppt_datapath.sv =====
// ---------------------------------------------------------------------------
// ppt_datapath
// Edge timing state, stop test, restoring divider and result register.
// ---------------------------------------------------------------------------
module ppt_datapath #(
	parameter int TIME_BITS     = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [31:0]                now_us,
	input  logic [ppt_pkg::CFG_W-1:0]  lockout_us,
	input  logic [ppt_pkg::CFG_W-1:0]  timeout_us,
	input  ppt_pkg::ppt_cmd_t          cmd,
	output ppt_pkg::ppt_sts_t          sts,
	output logic [ppt_pkg::RPM_W-1:0]  rpm_q8,
	output logic                       stopped
);

	localparam int NUM_W = ppt_pkg::RPM_BASE_W + FRACTION_BITS;
	localparam int CMP_W = (TIME_BITS > ppt_pkg::CFG_W) ? TIME_BITS : ppt_pkg::CFG_W;
	localparam logic [NUM_W-1:0] NUMER = NUM_W'(ppt_pkg::RPM_BASE) << FRACTION_BITS;

	logic [TIME_BITS-1:0]     last_q;
	logic [TIME_BITS-1:0]     interval_q;
	logic [TIME_BITS-1:0]     rem_q;
	logic [NUM_W-1:0]         num_q;
	logic [ppt_pkg::RPM_W-1:0] rpm_q;
	logic                     stopped_q;

	logic [TIME_BITS-1:0]     now_t;
	logic [TIME_BITS-1:0]     span;
	logic                     past_lockout;
	logic [TIME_BITS:0]       trial;
	logic                     ge;
	logic [TIME_BITS:0]       diff;
	logic                     sat;

	assign now_t        = TIME_BITS'(now_us);
	assign span         = now_t - last_q;
	assign past_lockout = CMP_W'(span) > CMP_W'(lockout_us);
	assign sts.stop_now = (CMP_W'(span) > CMP_W'(timeout_us)) || (interval_q == '0);

	// one quotient bit per step
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, interval_q};
	assign diff  = trial - {1'b0, interval_q};
	assign sat   = num_q[NUM_W-1:ppt_pkg::RPM_W] != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			interval_q <= '0;
			rpm_q      <= '0;
			stopped_q  <= 1'b0;
		end else begin
			if (cmd.edge_upd && past_lockout) begin
				interval_q <= span;
				last_q     <= now_t;
			end
			if (cmd.load_stop) begin
				rpm_q     <= '0;
				stopped_q <= 1'b1;
			end else if (cmd.load_div) begin
				rpm_q     <= sat ? ppt_pkg::RPM_MAX : num_q[ppt_pkg::RPM_W-1:0];
				stopped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			num_q <= NUMER;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign rpm_q8  = rpm_q;
	assign stopped = stopped_q;

	a_stop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> rpm_q == '0)
		else $error("stopped result carries a speed");

	a_interval_set: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.edge_upd && past_lockout) |=> interval_q != '0)
		else $error("accepted edge left no interval");

	a_bounce_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.edge_upd && !past_lockout) |=> $stable(last_q) && $stable(interval_q))
		else $error("bounce edge changed the timing state");

endmodule

// ===== rtl/core/pulse_period_tachometer.sv =====
// Edge event: accepted while the divider is idle, no result; edges may follow back to back.
// Query while stopped: result valid the cycle after the transfer.
// Running query: the restoring divider runs in S_DIV, then S_FIN loads the result once
//   the output slot is free; one quotient bit per cycle; one query in flight.
// Reset (arst_n low, asynchronous): lockout 3000, timeout 1000000, last edge
//   time and interval zero (no interval), no result pending.
// ---------------------------------------------------------------------------
// pulse_period_tachometer
// Measures edge-to-edge period with debounce and reports speed in RPM.
// ---------------------------------------------------------------------------
module pulse_period_tachometer #(
	parameter int TIME_BITS     = 32,
	parameter int FRACTION_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// event channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      command,
	input  logic [31:0]               now_us,
	// result channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [ppt_pkg::RPM_W-1:0] rpm_q8,
	output logic                      stopped
);

	logic [ppt_pkg::CFG_W-1:0]     lockout_q;
	logic [ppt_pkg::CFG_W-1:0]     timeout_q;
	logic [ppt_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          cfg_wr;
	ppt_pkg::ppt_cmd_t             cmd;
	ppt_pkg::ppt_sts_t             sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= ppt_pkg::LOCKOUT_RST;
			timeout_q <= ppt_pkg::TIMEOUT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				ppt_pkg::REG_LOCKOUT: lockout_q <= pwdata;
				ppt_pkg::REG_TIMEOUT: timeout_q <= pwdata;
				default: begin
					lockout_q <= lockout_q;
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ppt_pkg::REG_LOCKOUT: prdata = lockout_q;
			ppt_pkg::REG_TIMEOUT: prdata = timeout_q;
			default:              prdata = '0;
		endcase
	end

	ppt_ctrl #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	ppt_datapath #(
		.TIME_BITS    (TIME_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.now_us    (now_us),
		.lockout_us(lockout_q),
		.timeout_us(timeout_q),
		.cmd       (cmd),
		.sts       (sts),
		.rpm_q8    (rpm_q8),
		.stopped   (stopped)
	);

endmodule

// ===== tb/sv/pulse_period_tachometer_checker.sv =====
// ---------------------------------------------------------------------------
// pulse_period_tachometer_checker
// Watches the APB port, the event channel and the result channel, predicts every speed reading
// of the tachometer and compares it field by field with the block's output.
// ---------------------------------------------------------------------------
module pulse_period_tachometer_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	input  logic [31:0]               prdata,
	input  logic                      pready,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      command,
	input  logic [31:0]               now_us,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [ppt_pkg::RPM_W-1:0] rpm_q8,
	input  logic                      stopped,
	output int                        mismatch_count,
	output int                        open_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          FRACTION_BITS = 8;
	localparam logic [63:0] RPM_NUMERATOR = 64'(ppt_pkg::RPM_BASE) << FRACTION_BITS;

	typedef struct packed {
		logic [ppt_pkg::RPM_W-1:0] rpm;
		logic                      stopped;
	} reading_t;

	reading_t    expected_readings[$];
	logic [31:0] lockout_us;
	logic [31:0] timeout_us;
	logic [31:0] last_edge;
	logic [31:0] interval;
	int          errors;

	// Update the period state for an edge, queue the reading for a query.
	function automatic void advance_tachometer(input logic cmd, input logic [31:0] stamp);
		logic [31:0] span;
		logic [63:0] quot;
		reading_t    r;
		span = stamp - last_edge;
		if (cmd == ppt_pkg::CMD_EDGE) begin
			if (span > lockout_us) begin
				interval  = span;
				last_edge = stamp;
			end
		end else begin
			// timeout test first; no interval reads the same way
			if (span > timeout_us || interval == '0) begin
				r.rpm     = '0;
				r.stopped = 1'b1;
			end else begin
				quot      = RPM_NUMERATOR / interval;
				r.rpm     = (quot > ppt_pkg::RPM_MAX) ? ppt_pkg::RPM_MAX :
					quot[ppt_pkg::RPM_W-1:0];
				r.stopped = 1'b0;
			end
			expected_readings.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t    want;
		logic [31:0] reg_value;
		if (!arst_n) begin
			lockout_us = ppt_pkg::LOCKOUT_RST;
			timeout_us = ppt_pkg::TIMEOUT_RST;
			last_edge  = '0;
			interval   = '0;
			errors     = 0;
			expected_readings.delete();
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == ppt_pkg::REG_LOCKOUT)
						lockout_us = pwdata;
					else
						timeout_us = pwdata;
				end else begin
					reg_value = (paddr[2] == ppt_pkg::REG_LOCKOUT) ? lockout_us : timeout_us;
					if (prdata !== reg_value) begin
						$error("prdata: expected %0d, got %0d", reg_value, prdata);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				advance_tachometer(command, now_us);
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					$error("unexpected reading: rpm_q8 %0d stopped %0b", rpm_q8, stopped);
					errors++;
				end else begin
					want = expected_readings.pop_front();
					if (rpm_q8 !== want.rpm) begin
						$error("rpm_q8: expected %0d, got %0d", want.rpm, rpm_q8);
						errors++;
					end
					if (stopped !== want.stopped) begin
						$error("stopped: expected %0b, got %0b", want.stopped, stopped);
						errors++;
					end
				end
			end
		end
		mismatch_count <= errors;
		open_results   <= expected_readings.size();
	end

endmodule

// ===== tb/sv/pulse_period_tachometer_test.sv =====
// ---------------------------------------------------------------------------
// pulse_period_tachometer_test
// Drives edge and query events plus APB register writes and reads into the tachometer,
// with random gaps and output stalls; the checker beside the block predicts
// and compares every reading.
// ---------------------------------------------------------------------------
module pulse_period_tachometer_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_LIMIT   = 5000;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      psel      = 1'b0;
	logic                      penable   = 1'b0;
	logic                      pwrite    = 1'b0;
	logic [2:0]                paddr     = '0;
	logic [31:0]               pwdata    = '0;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic                      command   = ppt_pkg::CMD_EDGE;
	logic [31:0]               now_us    = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [ppt_pkg::RPM_W-1:0] rpm_q8;
	logic                      stopped;
	int                        mismatch_count;
	int                        open_results;

	bit               quiet      = 1'b0;
	int               stall_left = 0;
	int               idle_cycles = 0;

	pulse_period_tachometer u_dut (.*);

	pulse_period_tachometer_checker u_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hold each reading for a random number of cycles once it shows up.
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			stall_left = quiet ? 0 : $urandom_range(0, 17);
		else if (out_valid && stall_left != 0)
			stall_left--;
		out_stall <= (stall_left != 0);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_event(input logic cmd, input logic [31:0] stamp);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		now_us   <= stamp;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop the event channel and wait until every reading has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (open_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure_tach(input logic [31:0] lock, input logic [31:0] tmo);
		settle();
		apb_access(1'b1, {ppt_pkg::REG_LOCKOUT, 2'b00}, lock);
		apb_access(1'b1, {ppt_pkg::REG_TIMEOUT, 2'b00}, tmo);
		apb_access(1'b0, {ppt_pkg::REG_LOCKOUT, 2'b00}, '0);
		apb_access(1'b0, {ppt_pkg::REG_TIMEOUT, 2'b00}, '0);
	endtask

	initial begin
		logic [31:0] cursor;
		logic [31:0] lock;
		logic [31:0] tmo;
		logic [31:0] step;
		logic [31:0] offset;
		int          phase;
		int          n;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no interval yet, bounce at and past the lockout,
		// timeout boundary, wrap of the time stamp
		send_event(ppt_pkg::CMD_QUERY, 32'd0);
		send_event(ppt_pkg::CMD_QUERY, 32'h7FFF_FFFF);
		send_event(ppt_pkg::CMD_EDGE,  32'd100);
		send_event(ppt_pkg::CMD_QUERY, 32'd100);
		send_event(ppt_pkg::CMD_EDGE,  32'd3000);
		send_event(ppt_pkg::CMD_EDGE,  32'd3001);
		send_event(ppt_pkg::CMD_QUERY, 32'd3001);
		send_event(ppt_pkg::CMD_QUERY, 32'd1003001);
		send_event(ppt_pkg::CMD_QUERY, 32'd1003002);
		send_event(ppt_pkg::CMD_EDGE,  32'hFFFF_FFFF);
		send_event(ppt_pkg::CMD_EDGE,  32'h0000_1000);
		send_event(ppt_pkg::CMD_QUERY, 32'h0000_2000);

		// no lockout, widest timeout: one-tick interval saturates, full-range interval
		configure_tach('0, '1);
		send_event(ppt_pkg::CMD_EDGE,  32'h0000_1001);
		send_event(ppt_pkg::CMD_EDGE,  32'h0000_1001);
		send_event(ppt_pkg::CMD_QUERY, 32'h0000_1000);
		send_event(ppt_pkg::CMD_EDGE,  32'h0000_1000);
		send_event(ppt_pkg::CMD_QUERY, 32'h0000_1000);

		// lockout swallows every edge, zero timeout
		configure_tach('1, '0);
		send_event(ppt_pkg::CMD_EDGE,  32'd0);
		send_event(ppt_pkg::CMD_QUERY, 32'h0000_1000);
		send_event(ppt_pkg::CMD_QUERY, 32'h0000_1001);

		cursor = 32'h0000_1000;
		for (phase = 0; phase < 8; phase++) begin
			case ($urandom_range(0, 4))
				0:       lock = '0;
				1:       lock = $urandom_range(1, 1000);
				2:       lock = ppt_pkg::LOCKOUT_RST;
				3:       lock = $urandom_range(1000, 100000);
				default: lock = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0:       tmo = ppt_pkg::TIMEOUT_RST;
				1:       tmo = $urandom_range(0, 200000);
				2:       tmo = '1;
				default: tmo = $urandom;
			endcase
			configure_tach(lock, tmo);
			quiet = ($urandom_range(0, 3) == 0);
			for (n = 0; n < 48; n++) begin
				if ($urandom_range(0, 9) == 0) begin
					send_event(1'($urandom_range(0, 1)), $urandom);
				end else if ($urandom_range(0, 2) != 0) begin
					// advance the edge train around the lockout window
					case ($urandom_range(0, 4))
						0:       step = lock;
						1:       step = lock + 1;
						2:       step = lock - 1;
						3:       step = (lock < 32'd100000) ?
							$urandom_range(0, 2 * lock + 1000) : $urandom;
						default: step = $urandom_range(1, 1000);
					endcase
					cursor = cursor + step;
					send_event(ppt_pkg::CMD_EDGE, cursor);
				end else begin
					case ($urandom_range(0, 4))
						0:       offset = '0;
						1:       offset = tmo;
						2:       offset = tmo + 1;
						3:       offset = $urandom_range(0, 300000);
						default: offset = $urandom;
					endcase
					send_event(ppt_pkg::CMD_QUERY, cursor + offset);
				end
			end
		end

		quiet = 1'b0;
		settle();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/ppt_pkg.sv
rtl/core/ppt_ctrl.sv
rtl/core/ppt_datapath.sv
rtl/core/pulse_period_tachometer.sv
tb/sv/pulse_period_tachometer_checker.sv
tb/sv/pulse_period_tachometer_test.sv
